### src/particle_slot_pool_assert.svh
// ----------------------------------------------------------------------------
// particle_slot_pool assertion macros
// shared concurrent assertion forms used by the slot pool rtl
// ----------------------------------------------------------------------------
`ifndef PARTICLE_SLOT_POOL_ASSERT_SVH
`define PARTICLE_SLOT_POOL_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/psp_pkg.sv
// ----------------------------------------------------------------------------
// psp_pkg
// types, constants and helpers for the particle slot pool
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psp_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ACT_W      = $clog2(SLOT_COUNT + 1);
    localparam int FRAME_LAST = 3;
    localparam logic [7:0] FRAME_TICKS_RST = 8'd3;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_SPAWN = 2'd1,
        MODE_GROUP = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SPAWN_WR,
        ST_TICK_OUT,
        ST_RD_ADDR,
        ST_RD_OUT
    } t_state;

    typedef struct packed {
        logic        on;
        logic [15:0] x;
        logic [15:0] y;
        logic [1:0]  frm;
        logic [7:0]  tmr;
        logic        grp;
        logic [1:0]  variant;
    } t_slot;

    function automatic logic [2:0] slot_code(input logic [SLOT_AW-1:0] idx);
        logic [63:0] w;
        w = 64'(idx);
        return w[2:0];
    endfunction

    function automatic logic [3:0] sat_total(input logic [ACT_W-1:0] n);
        logic [63:0] w;
        w = 64'(n);
        return (w > 64'd15) ? 4'd15 : w[3:0];
    endfunction

endpackage

### src/particle_slot_pool.sv
// ----------------------------------------------------------------------------
// particle_slot_pool
// pool of animated effect slots kept in a synchronous-read memory
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_stall carry one transaction holding mode,
// position and read index. output channel: o_out_valid / i_out_stall return
// exactly one result transaction per input transaction.
// tick and spawn sweep the slot memory once, one read per cycle; a tick
// writes back the previous slot, if active, in the same cycle. the block
// stalls its input until the current item has handed its result to the
// output register. a read sets the memory address, then captures the slot.
// the block takes a new transaction whenever it is idle, even while the last
// result still waits in the output register; it holds a finished result
// until the output register is free.
// reset clears the per-slot valid bits (all slots read as zero, inactive),
// the variant counter, the active count and sets frame_ticks to 3. no
// clearing pass is needed.
// i_cfg_we writes frame_ticks; write it only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "particle_slot_pool_assert.svh"

module particle_slot_pool
    import psp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [2:0]  i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_slot_used,
    output logic        o_evicted,
    output logic        o_slot_active,
    output logic signed [15:0] o_slot_x,
    output logic signed [15:0] o_slot_y,
    output logic [1:0]  o_slot_frame,
    output logic        o_slot_group,
    output logic [1:0]  o_slot_variant,
    output logic [3:0]  o_active_total
);

    t_slot               mem [SLOT_COUNT];
    t_slot               r_rd_data;
    logic                r_rd_vbit;
    logic [SLOT_COUNT-1:0] r_slot_vld;

    t_state              r_state, n_state;
    t_mode               r_mode;
    logic [15:0]         r_pos_x, r_pos_y;
    logic [2:0]          r_read_index;
    logic [7:0]          r_frame_ticks;
    logic [1:0]          r_var_cnt;
    logic [ACT_W-1:0]    r_act_cnt;

    logic [SLOT_AW-1:0]  r_idx, r_wb_idx;
    logic                r_issue_on, r_pend;
    logic                r_free_fnd;
    logic [SLOT_AW-1:0]  r_free_idx, r_best_idx;
    logic [1:0]          r_best_frm;

    logic                r_out_vld;
    logic [2:0]          r_res_used;
    logic                r_res_evicted;
    t_slot               r_res_slot;
    logic [3:0]          r_res_total;

    logic                w_in_acc, w_out_free, w_scan_done, w_rd_inrange;
    t_slot               w_cur, w_ticked, w_new;
    logic                w_retire;
    logic [SLOT_AW-1:0]  w_pick;

    logic                mem_re, mem_we;
    logic [SLOT_AW-1:0]  mem_raddr, mem_waddr;
    t_slot               mem_wdata;
    logic                res_load;
    logic [2:0]          res_used;
    logic                res_evicted;
    t_slot               res_slot;
    logic [3:0]          res_total;

    assign o_in_stall   = (r_state != ST_IDLE);
    assign w_in_acc     = i_in_valid && !o_in_stall;
    assign w_out_free   = !r_out_vld || !i_out_stall;
    assign w_scan_done  = r_pend && !r_issue_on;
    assign w_rd_inrange = (int'(r_read_index) < SLOT_COUNT);
    assign w_cur        = r_rd_vbit ? r_rd_data : '0;
    assign w_pick       = r_free_fnd ? r_free_idx : r_best_idx;

    // per-slot tick update
    always_comb begin
        w_ticked = w_cur;
        w_retire = 1'b0;
        if (w_cur.tmr != 8'd0) begin
            w_ticked.tmr = 8'(w_cur.tmr - 8'd1);
        end else if (w_cur.frm == 2'(FRAME_LAST)) begin
            w_ticked.frm = 2'd0;
            w_ticked.on  = 1'b0;
            w_retire     = 1'b1;
        end else begin
            w_ticked.frm = 2'(w_cur.frm + 2'd1);
            w_ticked.tmr = r_frame_ticks;
        end
    end

    always_comb begin
        w_new.on      = 1'b1;
        w_new.x       = r_pos_x;
        w_new.y       = r_pos_y;
        w_new.frm     = 2'd0;
        w_new.tmr     = r_frame_ticks;
        w_new.grp     = (r_mode == MODE_GROUP);
        w_new.variant = (r_mode == MODE_GROUP) ? r_var_cnt : 2'd0;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (t_mode'(i_mode) == MODE_READ) ? ST_RD_ADDR : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = (r_mode == MODE_TICK) ? ST_TICK_OUT : ST_SPAWN_WR;
                end
            end
            ST_RD_ADDR:  n_state = ST_RD_OUT;
            ST_SPAWN_WR,
            ST_TICK_OUT,
            ST_RD_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // memory control and result selection
    always_comb begin
        mem_re      = 1'b0;
        mem_raddr   = r_idx;
        mem_we      = 1'b0;
        mem_waddr   = r_wb_idx;
        mem_wdata   = w_ticked;
        res_load    = 1'b0;
        res_used    = 3'd0;
        res_evicted = 1'b0;
        res_slot    = '0;
        res_total   = sat_total(r_act_cnt);
        unique case (r_state)
            ST_SCAN: begin
                mem_re = r_issue_on;
                mem_we = r_pend && (r_mode == MODE_TICK) && w_cur.on;
            end
            ST_SPAWN_WR: begin
                mem_we      = w_out_free;
                mem_waddr   = w_pick;
                mem_wdata   = w_new;
                res_load    = w_out_free;
                res_used    = slot_code(w_pick);
                res_evicted = !r_free_fnd;
                res_slot    = w_new;
                res_total   = sat_total(ACT_W'(r_act_cnt + ACT_W'(r_free_fnd)));
            end
            ST_TICK_OUT: begin
                res_load = w_out_free;
            end
            ST_RD_ADDR: begin
                mem_re    = w_rd_inrange;
                mem_raddr = SLOT_AW'(r_read_index);
            end
            ST_RD_OUT: begin
                res_load = w_out_free;
                res_used = r_read_index;
                res_slot = w_rd_inrange ? w_cur : '0;
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_slot_vld    <= '0;
            r_rd_vbit     <= 1'b0;
            r_frame_ticks <= FRAME_TICKS_RST;
            r_var_cnt     <= 2'd0;
            r_act_cnt     <= '0;
            r_issue_on    <= 1'b0;
            r_pend        <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_frame_ticks <= i_cfg_wdata;
            end
            if (mem_we) begin
                r_slot_vld[mem_waddr] <= 1'b1;
            end
            if (mem_re) begin
                r_rd_vbit <= r_slot_vld[mem_raddr];
            end

            if (w_in_acc) begin
                r_issue_on <= 1'b1;
                r_pend     <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_pend <= r_issue_on;
                if (r_issue_on && (r_idx == SLOT_AW'(SLOT_COUNT - 1))) begin
                    r_issue_on <= 1'b0;
                end
            end

            if ((r_state == ST_SCAN) && r_pend && (r_mode == MODE_TICK)
                    && w_cur.on && w_retire) begin
                r_act_cnt <= ACT_W'(r_act_cnt - ACT_W'(1));
            end else if ((r_state == ST_SPAWN_WR) && w_out_free && r_free_fnd) begin
                r_act_cnt <= ACT_W'(r_act_cnt + ACT_W'(1));
            end

            if ((r_state == ST_SPAWN_WR) && w_out_free && (r_mode == MODE_GROUP)) begin
                r_var_cnt <= 2'(r_var_cnt + 2'd1);
            end

            if (res_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // transaction capture, sweep counters, pick tracking and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode       <= t_mode'(i_mode);
            r_pos_x      <= i_pos_x;
            r_pos_y      <= i_pos_y;
            r_read_index <= i_read_index;
            r_idx        <= '0;
            r_free_fnd   <= 1'b0;
            r_free_idx   <= '0;
            r_best_idx   <= '0;
            r_best_frm   <= 2'd0;
        end else if (r_state == ST_SCAN) begin
            r_wb_idx <= r_idx;
            if (r_issue_on && (r_idx != SLOT_AW'(SLOT_COUNT - 1))) begin
                r_idx <= SLOT_AW'(r_idx + SLOT_AW'(1));
            end
            if (r_pend) begin
                if (!r_free_fnd && !w_cur.on) begin
                    r_free_fnd <= 1'b1;
                    r_free_idx <= r_wb_idx;
                end
                if (w_cur.on && (w_cur.frm > r_best_frm)) begin
                    r_best_frm <= w_cur.frm;
                    r_best_idx <= r_wb_idx;
                end
            end
        end
        if (res_load) begin
            r_res_used    <= res_used;
            r_res_evicted <= res_evicted;
            r_res_slot    <= res_slot;
            r_res_total   <= res_total;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_slot_used    = r_res_used;
    assign o_evicted      = r_res_evicted;
    assign o_slot_active  = r_res_slot.on;
    assign o_slot_x       = r_res_slot.x;
    assign o_slot_y       = r_res_slot.y;
    assign o_slot_frame   = r_res_slot.frm;
    assign o_slot_group   = r_res_slot.grp;
    assign o_slot_variant = r_res_slot.variant;
    assign o_active_total = r_res_total;

    `PSP_ASSERT_NOW(a_cnt_bound, 1'b1, int'(r_act_cnt) <= SLOT_COUNT, "active count overflow")
    `PSP_ASSERT_NOW(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr, "memory rw clash")
    `PSP_ASSERT_NEXT(a_busy_after_acc, w_in_acc, r_state != ST_IDLE, "accept left block idle")
    `PSP_ASSERT_NEXT(a_spawn_result, (r_state == ST_SPAWN_WR) && w_out_free, o_out_valid && o_slot_active, "spawn result missing")

endmodule

### sim/particle_slot_pool_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_slot_pool_test
// drives ticks, spawns, group spawns and slot reads into the slot pool under
// random handshake idling and one long output hold-off, mirrors the pool in
// the bench and checks every result transaction field by field
// ----------------------------------------------------------------------------

module particle_slot_pool_test;
    import psp_pkg::*;

    typedef struct packed {
        logic        on;
        logic [15:0] x;
        logic [15:0] y;
        logic [1:0]  frame;
        logic [7:0]  timer;
        logic        grp;
        logic [1:0]  variant;
    } effect_slot_t;

    typedef struct packed {
        logic [2:0]  slot_used;
        logic        evicted;
        logic        active;
        logic [15:0] x;
        logic [15:0] y;
        logic [1:0]  frame;
        logic        grp;
        logic [1:0]  variant;
        logic [3:0]  total;
    } slot_report_t;

    class pool_mirror;
        effect_slot_t slots [SLOT_COUNT];
        logic [1:0]   next_variant;
        logic [7:0]   reload;
        slot_report_t awaited [$];
        int           errors;
        int           ticks;
        int           spawns;
        int           evictions;
        int           retirements;
        int           reads;

        function new();
            foreach (slots[i]) slots[i] = '0;
            next_variant = 2'd0;
            // reload value after reset
            reload       = 8'd3;
            errors       = 0;
            ticks        = 0;
            spawns       = 0;
            evictions    = 0;
            retirements  = 0;
            reads        = 0;
        endfunction

        function slot_report_t with_slot(slot_report_t r, int idx);
            r.active  = slots[idx].on;
            r.x       = slots[idx].x;
            r.y       = slots[idx].y;
            r.frame   = slots[idx].frame;
            r.grp     = slots[idx].grp;
            r.variant = slots[idx].variant;
            return r;
        endfunction

        function void note_item(t_mode m, logic [15:0] px, logic [15:0] py, logic [2:0] ri);
            slot_report_t r;
            int           pick;
            int           n;
            logic [1:0]   best_frame;
            r = '0;
            n = 0;
            case (m)
                MODE_TICK: begin
                    ticks++;
                    foreach (slots[i]) begin
                        if (slots[i].on) begin
                            if (slots[i].timer != 8'd0) begin
                                slots[i].timer--;
                            end else if (slots[i].frame == 2'd3) begin
                                slots[i].frame = 2'd0;
                                slots[i].on    = 1'b0;
                                retirements++;
                            end else begin
                                slots[i].frame++;
                                slots[i].timer = reload;
                            end
                        end
                    end
                end
                MODE_SPAWN, MODE_GROUP: begin
                    pick = -1;
                    for (int i = 0; i < SLOT_COUNT && pick < 0; i++) begin
                        if (!slots[i].on) pick = i;
                    end
                    // full pool: first slot with the highest frame
                    if (pick < 0) begin
                        pick       = 0;
                        best_frame = 2'd0;
                        for (int i = 0; i < SLOT_COUNT; i++) begin
                            if (slots[i].frame > best_frame) begin
                                best_frame = slots[i].frame;
                                pick       = i;
                            end
                        end
                    end
                    spawns++;
                    r.slot_used = 3'(pick);
                    r.evicted   = slots[pick].on;
                    if (slots[pick].on) evictions++;
                    slots[pick].on    = 1'b1;
                    slots[pick].x     = px;
                    slots[pick].y     = py;
                    slots[pick].frame = 2'd0;
                    slots[pick].timer = reload;
                    if (m == MODE_GROUP) begin
                        slots[pick].grp     = 1'b1;
                        slots[pick].variant = next_variant;
                        next_variant++;
                    end else begin
                        slots[pick].grp     = 1'b0;
                        slots[pick].variant = 2'd0;
                    end
                    r = with_slot(r, pick);
                end
                default: begin
                    reads++;
                    r.slot_used = ri;
                    if (int'(ri) < SLOT_COUNT) r = with_slot(r, int'(ri));
                end
            endcase
            foreach (slots[i]) if (slots[i].on) n++;
            r.total = (n > 15) ? 4'd15 : 4'(n);
            awaited.push_back(r);
        endfunction

        function void diff(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(slot_report_t got);
            slot_report_t want;
            if (awaited.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
                return;
            end
            want = awaited.pop_front();
            diff("slot_used", 32'(want.slot_used), 32'(got.slot_used));
            diff("evicted", 32'(want.evicted), 32'(got.evicted));
            diff("slot_active", 32'(want.active), 32'(got.active));
            diff("slot_x", 32'(want.x), 32'(got.x));
            diff("slot_y", 32'(want.y), 32'(got.y));
            diff("slot_frame", 32'(want.frame), 32'(got.frame));
            diff("slot_group", 32'(want.grp), 32'(got.grp));
            diff("slot_variant", 32'(want.variant), 32'(got.variant));
            diff("active_total", 32'(want.total), 32'(got.total));
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n      = 1'b0;
    logic               i_cfg_we     = 1'b0;
    logic [7:0]         i_cfg_wdata  = 8'd0;
    logic               i_in_valid   = 1'b0;
    logic [1:0]         i_mode       = 2'd0;
    logic signed [15:0] i_pos_x      = 16'sd0;
    logic signed [15:0] i_pos_y      = 16'sd0;
    logic [2:0]         i_read_index = 3'd0;
    logic               i_out_stall  = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [2:0]         o_slot_used;
    logic               o_evicted;
    logic               o_slot_active;
    logic signed [15:0] o_slot_x;
    logic signed [15:0] o_slot_y;
    logic [1:0]         o_slot_frame;
    logic               o_slot_group;
    logic [1:0]         o_slot_variant;
    logic [3:0]         o_active_total;

    slot_report_t seen;
    pool_mirror   book;
    int           send_gap_pct   = 0;
    int           recv_stall_pct = 0;
    int           hold_left      = 0;

    assign seen = '{slot_used: o_slot_used, evicted: o_evicted, active: o_slot_active,
                    x: o_slot_x, y: o_slot_y, frame: o_slot_frame, grp: o_slot_group,
                    variant: o_slot_variant, total: o_active_total};

    particle_slot_pool u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_read_index   (i_read_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_slot_used    (o_slot_used),
        .o_evicted      (o_evicted),
        .o_slot_active  (o_slot_active),
        .o_slot_x       (o_slot_x),
        .o_slot_y       (o_slot_y),
        .o_slot_frame   (o_slot_frame),
        .o_slot_group   (o_slot_group),
        .o_slot_variant (o_slot_variant),
        .o_active_total (o_active_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("particle_slot_pool_test: errors");
        $finish;
    end

    // result side: check accepted transactions, then pick the next stall
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) book.check_report(seen);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    task automatic offer(input t_mode m, input logic [15:0] px, input logic [15:0] py,
                         input logic [2:0] ri);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= m;
        i_pos_x      <= px;
        i_pos_y      <= py;
        i_read_index <= ri;
        do @(posedge i_clk); while (o_in_stall);
        book.note_item(m, px, py, ri);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (book.awaited.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_reload(input logic [7:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        book.reload = v;
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic run_random(input int count);
        t_mode m;
        int    tick_pct;
        tick_pct = 40;
        for (int k = 0; k < count; k++) begin
            // vary the tick share so the pool both drains and fills to eviction
            if (k % 40 == 0) tick_pct = $urandom_range(15, 70);
            if ($urandom_range(99) < tick_pct) begin
                m = MODE_TICK;
            end else begin
                case ($urandom_range(2))
                    0:       m = MODE_SPAWN;
                    1:       m = MODE_GROUP;
                    default: m = MODE_READ;
                endcase
            end
            offer(m, pick_coord(), pick_coord(), 3'($urandom_range(7)));
        end
    endtask

    initial begin
        book = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset reload value, empty read, extremes of position
        offer(MODE_READ, 16'h0000, 16'h0000, 3'd7);
        offer(MODE_SPAWN, 16'h7FFF, 16'h8000, 3'd0);
        offer(MODE_GROUP, 16'h8000, 16'h7FFF, 3'd0);
        repeat (4) offer(MODE_TICK, 16'h0000, 16'h0000, 3'd0);
        offer(MODE_READ, 16'h0000, 16'h0000, 3'd0);

        // fill the pool, variant wraps, then evict and retire
        set_reload(8'd0);
        repeat (4) offer(MODE_GROUP, 16'h1234, 16'hEDCB, 3'd0);
        offer(MODE_SPAWN, 16'h0000, 16'hFFFF, 3'd0);
        offer(MODE_SPAWN, 16'hFFFF, 16'h0000, 3'd0);
        repeat (2) offer(MODE_TICK, 16'h0000, 16'h0000, 3'd0);
        offer(MODE_SPAWN, 16'h4321, 16'hBCDE, 3'd0);
        offer(MODE_READ, 16'h0000, 16'h0000, 3'd2);
        repeat (2) offer(MODE_TICK, 16'h0000, 16'h0000, 3'd0);
        offer(MODE_READ, 16'h0000, 16'h0000, 3'd3);

        send_gap_pct   = 37;
        recv_stall_pct = 67;
        run_random(300);

        set_reload(8'd255);
        send_gap_pct   = 67;
        recv_stall_pct = 37;
        run_random(300);

        set_reload(8'd1);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        run_random(150);

        set_reload(8'd2);
        hold_left = 400;
        run_random(150);

        wait_drained();
        repeat (16) @(posedge i_clk);
        $display("covered %0d ticks, %0d spawns with %0d evictions, %0d retirements, %0d reads",
                 book.ticks, book.spawns, book.evictions, book.retirements, book.reads);
        $display("frame reload values 3, 0, 255, 1 and 2, with idling and a long output hold");
        if (book.errors == 0) begin
            $display("particle_slot_pool_test: clean");
        end else begin
            $display("particle_slot_pool_test: errors");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/psp_pkg.sv
src/particle_slot_pool.sv
sim/particle_slot_pool_test.sv
